// ===== sv/ties_pkg.sv =====
`default_nettype none

package ties_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TIME_W     = 32;
   localparam int DL_W       = TIME_W + 1;
   localparam int LEVEL_W    = 3;
   localparam int INFO_W     = 16;
   localparam int MASK_W     = 8;

   typedef logic [SLOT_COUNT-1:0] slot_mask_type;
   typedef logic [SLOT_W-1:0]     slot_idx_type;
   typedef logic [DL_W-1:0]       deadline_type;
   typedef logic [INFO_W-1:0]     info_type;

   localparam deadline_type DL_NONE = '1;

   localparam logic REQ_REGISTER = 1'b0;
   localparam logic REQ_POLL     = 1'b1;

   // CPU priority levels that shape the enable mask
   localparam logic [LEVEL_W-1:0] LEVEL_ALL_MAX = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_SLOT0   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic arm;
      logic fire;
      logic scan;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_poll;
      logic poll_go;
      logic scan_last;
   } dp_status_type;

   function automatic slot_mask_type enable_for(input logic [LEVEL_W-1:0] cpu_level);
      slot_mask_type en;
      priority if (cpu_level <= LEVEL_ALL_MAX) begin
         en = '1;
      end else if (cpu_level == LEVEL_SLOT0) begin
         en = slot_mask_type'(1);
      end else begin
         en = '0;
      end
      return en;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ties_ctrl.sv =====
`default_nettype none

module ties_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   output ties_pkg::dp_cmd_type        cmd,
   input  wire ties_pkg::dp_status_type status
);
   import ties_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!status.is_poll) begin
               cmd.arm  = 1'b1;
               state_in = ST_DONE;
            end else if (status.poll_go) begin
               cmd.fire = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/ties_dp.sv =====
`default_nettype none

module ties_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ties_pkg::dp_cmd_type          cmd,
   output ties_pkg::dp_status_type            status,
   input  wire logic                          req_type,
   input  wire logic [ties_pkg::TIME_W-1:0]   req_now,
   input  wire logic [ties_pkg::LEVEL_W-1:0]  req_level,
   input  wire logic [ties_pkg::TIME_W-1:0]   req_delay,
   input  wire logic [ties_pkg::INFO_W-1:0]   req_event_info,
   output logic                               rsp_fired,
   output logic [ties_pkg::LEVEL_W-1:0]       rsp_fired_slot,
   output logic [ties_pkg::INFO_W-1:0]        rsp_fired_info,
   output logic [ties_pkg::MASK_W-1:0]        rsp_pending_mask
);
   import ties_pkg::*;

   // captured request
   logic                 req_type_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [LEVEL_W-1:0]   level_ff;
   logic [TIME_W-1:0]    delay_ff;
   info_type             info_ff;

   // scheduler state
   slot_mask_type        pending_ff, pending_in;
   deadline_type         earliest_ff, earliest_in;
   deadline_type         dl_ff [SLOT_COUNT];
   info_type             sinfo_ff [SLOT_COUNT];

   // result and scan registers
   logic                 fired_ff, fired_in;
   logic [LEVEL_W-1:0]   fslot_ff, fslot_in;
   info_type             finfo_ff, finfo_in;
   slot_idx_type         idx_ff, idx_in;
   deadline_type         min_ff, min_in;

   slot_idx_type         arm_idx;
   logic                 arm_ok;
   deadline_type         when;
   deadline_type         now_ext;
   slot_mask_type        en;
   slot_mask_type        due;
   slot_mask_type        cand;
   slot_idx_type         pick;
   logic                 any_due;
   deadline_type         scan_dl;

   assign arm_idx = slot_idx_type'(level_ff);
   assign arm_ok  = (int'(level_ff) < SLOT_COUNT) && !pending_ff[arm_idx];
   assign when    = deadline_type'(now_ff) + deadline_type'(delay_ff);
   assign now_ext = deadline_type'(now_ff);
   assign en      = enable_for(level_ff);

   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         due[k] = now_ext >= dl_ff[k];
      end
   end

   assign cand    = en & pending_ff & due;
   assign any_due = |cand;

   // lowest-numbered candidate wins
   always_comb begin
      pick = '0;
      for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
         if (cand[k]) begin
            pick = slot_idx_type'(k);
         end
      end
   end

   assign scan_dl = dl_ff[idx_ff];

   assign status.is_poll   = (req_type_ff == REQ_POLL);
   assign status.poll_go   = (|(en & pending_ff)) && (now_ext >= earliest_ff);
   assign status.scan_last = (idx_ff == slot_idx_type'(SLOT_COUNT - 1));

   always_comb begin
      pending_in  = pending_ff;
      earliest_in = earliest_ff;
      fired_in    = fired_ff;
      fslot_in    = fslot_ff;
      finfo_in    = finfo_ff;
      idx_in      = idx_ff;
      min_in      = min_ff;
      if (cmd.capture) begin
         fired_in = 1'b0;
         fslot_in = '0;
         finfo_in = '0;
      end
      if (cmd.arm && arm_ok) begin
         pending_in[arm_idx] = 1'b1;
         if ((pending_ff == '0) || (when < earliest_ff)) begin
            earliest_in = when;
         end
      end
      if (cmd.fire) begin
         if (any_due) begin
            pending_in[pick] = 1'b0;
            fired_in         = 1'b1;
            fslot_in         = LEVEL_W'(pick);
            finfo_in         = sinfo_ff[pick];
         end
         idx_in = '0;
         min_in = DL_NONE;
      end
      if (cmd.scan) begin
         if (pending_ff[idx_ff] && (scan_dl < min_ff)) begin
            min_in = scan_dl;
         end
         idx_in = idx_ff + slot_idx_type'(1);
         if (cmd.commit) begin
            earliest_in = min_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         earliest_ff <= '0;
      end else begin
         pending_ff  <= pending_in;
         earliest_ff <= earliest_in;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff <= fired_in;
      fslot_ff <= fslot_in;
      finfo_ff <= finfo_in;
      idx_ff   <= idx_in;
      min_ff   <= min_in;
      if (cmd.capture) begin
         req_type_ff <= req_type;
         now_ff      <= req_now;
         level_ff    <= req_level;
         delay_ff    <= req_delay;
         info_ff     <= req_event_info;
      end
      if (cmd.arm && arm_ok) begin
         dl_ff[arm_idx]    <= when;
         sinfo_ff[arm_idx] <= info_ff;
      end
   end

   assign rsp_fired        = fired_ff;
   assign rsp_fired_slot   = fslot_ff;
   assign rsp_fired_info   = finfo_ff;
   assign rsp_pending_mask = MASK_W'(pending_ff);

endmodule

`default_nettype wire

// ===== sv/timed_interrupt_event_scheduler_core.sv =====
// A register request, or a poll with no enabled slot pending or taken before
//   the earliest deadline, goes from EXEC to DONE; any other poll goes on to SCAN,
//   which recomputes the earliest deadline (one slot deadline compared per cycle).
// A new request is accepted only in IDLE, after the previous result strobe.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Synchronous reset clears the pending slots and the earliest deadline.
`default_nettype none

module timed_interrupt_event_scheduler_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [ties_pkg::TIME_W-1:0]   req_now,
   input  wire logic [ties_pkg::LEVEL_W-1:0]  req_level,
   input  wire logic [ties_pkg::TIME_W-1:0]   req_delay,
   input  wire logic [ties_pkg::INFO_W-1:0]   req_event_info,
   output logic                               rsp_valid,
   output logic                               rsp_fired,
   output logic [ties_pkg::LEVEL_W-1:0]       rsp_fired_slot,
   output logic [ties_pkg::INFO_W-1:0]        rsp_fired_info,
   output logic [ties_pkg::MASK_W-1:0]        rsp_pending_mask
);
   import ties_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ties_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   ties_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_type),
      .req_now          (req_now),
      .req_level        (req_level),
      .req_delay        (req_delay),
      .req_event_info   (req_event_info),
      .rsp_fired        (rsp_fired),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_fired_info   (rsp_fired_info),
      .rsp_pending_mask (rsp_pending_mask)
   );

endmodule

`default_nettype wire

// ===== sv/ties_checker.sv =====
`default_nettype none

module ties_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_fired,
   input wire logic [ties_pkg::LEVEL_W-1:0]  rsp_fired_slot,
   input wire logic [ties_pkg::INFO_W-1:0]   rsp_fired_info,
   input wire logic [ties_pkg::MASK_W-1:0]   rsp_pending_mask
);
   import ties_pkg::*;

   // a request in flight blocks new ones
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting a request");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy window");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe not followed by idle");

   a_no_fire_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fired) |-> (rsp_fired_slot == '0 && rsp_fired_info == '0))
      else $error("non-firing result carries slot or info");

   a_fired_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fired) |-> !rsp_pending_mask[rsp_fired_slot])
      else $error("fired slot still pending");

endmodule

bind timed_interrupt_event_scheduler_core ties_checker u_ties_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_fired        (rsp_fired),
   .rsp_fired_slot   (rsp_fired_slot),
   .rsp_fired_info   (rsp_fired_info),
   .rsp_pending_mask (rsp_pending_mask)
);

`default_nettype wire
